// File: rtl/assert_macros.svh
// Assertion helpers shared by the RTL. Each expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that holds at every clock edge out of reset.
`define ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// A trigger that forces a condition in the following clock cycle.
`define ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// File: rtl/pcxrle_pkg.sv
package pcxrle_pkg;

    localparam int CFG_DATA_W = 13;

    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_DEPTH  = 2'd2;
    localparam logic [1:0] REG_PLANES = 2'd3;

    localparam logic [7:0] RUN_MARK  = 8'hC0;
    localparam logic [7:0] RUN_MASK  = 8'h3F;
    localparam logic [7:0] BYTE_MASK = 8'hFF;

    typedef struct packed {
        logic [12:0] width;
        logic [12:0] height;
        logic [3:0]  planes;
        logic [1:0]  depth;
        logic [12:0] line_bytes;
    } geom_t;

    typedef struct packed {
        logic accept;
        logic step;
    } dp_cmd_t;

    typedef struct packed {
        logic start_run;
        logic cnt_zero;
        logic cnt_last;
        logic emit;
        logic out_blocked;
    } dp_status_t;

    // Splits one data byte into its pixel fields and moves each to its plane bits.
    function automatic logic [63:0] unpack_lanes(logic [7:0] value, logic [1:0] depth,
                                                 logic [2:0] plane, logic [3:0] lanes);
        logic [63:0] packed_lanes;
        logic [3:0]  pix;
        logic [3:0]  bits;
        logic [5:0]  sh;
        logic [7:0]  fmask;
        logic [7:0]  f;
        logic [2:0]  amt;
        logic [15:0] wide;
        packed_lanes = '0;
        pix  = 4'd8 >> depth;
        bits = 4'd1 << depth;
        sh   = {2'b00, bits} * {3'b000, plane};
        case (depth)
            2'd0:    fmask = 8'h01;
            2'd1:    fmask = 8'h03;
            2'd2:    fmask = 8'h0F;
            default: fmask = BYTE_MASK;
        endcase
        for (int i = 0; i < 8; i++) begin
            if (4'(i) < lanes) begin
                amt  = 3'(int'(bits) * (int'(pix) - 1 - i));
                f    = (value >> amt) & fmask;
                wide = {8'h00, f} << sh;
                packed_lanes[8*i +: 8] = wide[7:0];
            end
        end
        return packed_lanes;
    endfunction

endpackage

// File: rtl/pcxrle_cfg.sv
module pcxrle_cfg
    import pcxrle_pkg::*;
#(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [1:0]            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output geom_t                 geom
);

    localparam logic [12:0] W_CAP = (MAX_WIDTH > 8191) ? 13'd8191 : 13'(MAX_WIDTH);
    localparam logic [12:0] H_CAP = (MAX_HEIGHT > 8191) ? 13'd8191 : 13'(MAX_HEIGHT);

    logic [12:0] width_reg;
    logic [12:0] height_reg;
    logic [1:0]  depth_reg;
    logic [3:0]  planes_reg;

    logic [12:0] w;
    logic [13:0] lb_sum;
    logic [3:0]  pix_m1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 13'd1;
            height_reg <= 13'd1;
            depth_reg  <= 2'd3;
            planes_reg <= 4'd1;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_WIDTH:  width_reg  <= cfg_data[12:0];
                REG_HEIGHT: height_reg <= cfg_data[12:0];
                REG_DEPTH:  depth_reg  <= cfg_data[1:0];
                REG_PLANES: planes_reg <= cfg_data[3:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        if (width_reg == 13'd0)
            w = 13'd1;
        else if (width_reg > W_CAP)
            w = W_CAP;
        else
            w = width_reg;

        if (height_reg == 13'd0)
            geom.height = 13'd1;
        else if (height_reg > H_CAP)
            geom.height = H_CAP;
        else
            geom.height = height_reg;

        if (planes_reg == 4'd0)
            geom.planes = 4'd1;
        else if (planes_reg > 4'd8)
            geom.planes = 4'd8;
        else
            geom.planes = planes_reg;

        // Bytes per line round up to whole bytes of packed pixels.
        pix_m1          = (4'd8 >> depth_reg) - 4'd1;
        lb_sum          = 14'(w) + 14'(pix_m1);
        geom.line_bytes = 13'(lb_sum >> (2'd3 - depth_reg));
        geom.width      = w;
        geom.depth      = depth_reg;
    end

endmodule

// File: rtl/pcxrle_ctrl.sv
`include "assert_macros.svh"

module pcxrle_ctrl
    import pcxrle_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  dp_status_t st,
    output dp_cmd_t    cmd
);

    typedef enum logic [1:0] {
        S_IN  = 2'b01,
        S_RUN = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   run_end;

    assign in_ready   = (state_reg == S_IN);
    assign cmd.accept = in_valid && in_ready;
    // A step that would produce a beat waits while the output register is full and not taken.
    assign cmd.step   = (state_reg == S_RUN) && !(st.emit && st.out_blocked);
    assign run_end    = cmd.step && (st.cnt_zero || st.cnt_last);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IN:
            begin
                if (cmd.accept && st.start_run)
                    state_next = S_RUN;
            end
            S_RUN:
            begin
                if (run_end)
                    state_next = S_IN;
            end
            default: state_next = S_IN;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IN;
        else
            state_reg <= state_next;
    end

    `ASSERT_NEXT(a_run_exit, (state_reg == S_RUN) && run_end, state_reg == S_IN, "run did not end")
    `ASSERT_NEXT(a_run_enter, cmd.accept && st.start_run, state_reg == S_RUN, "run not started")
    `ASSERT_ALWAYS(a_no_step_idle, !(cmd.step && cmd.accept), "step and accept together")

endmodule

// File: rtl/pcxrle_dp.sv
`include "assert_macros.svh"

module pcxrle_dp
    import pcxrle_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  geom_t       geom,
    input  dp_cmd_t     cmd,
    output dp_status_t  st,
    input  logic [7:0]  stream_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [11:0] row_index,
    output logic [2:0]  plane_index,
    output logic [11:0] first_column,
    output logic [3:0]  lane_count,
    output logic [63:0] pixel_lanes,
    output logic        last_of_run,
    output logic        picture_done
);

    logic        await_reg,    await_next;
    logic [5:0]  run_len_reg,  run_len_next;
    logic [11:0] row_reg,      row_next;
    logic [2:0]  plane_reg,    plane_next;
    logic [12:0] col_reg,      col_next;
    logic        finished_reg, finished_next;
    logic [5:0]  cnt_reg,      cnt_next;
    logic [7:0]  value_reg,    value_next;
    logic        out_valid_reg, out_valid_next;

    logic [11:0] row_out_reg;
    logic [2:0]  plane_out_reg;
    logic [11:0] col_out_reg;
    logic [3:0]  lanes_out_reg;
    logic [63:0] pixels_out_reg;
    logic        last_out_reg;
    logic        done_out_reg;

    logic [3:0]  pix;
    logic [12:0] col0;
    logic [12:0] diff;
    logic [3:0]  lanes;
    logic        last_line;
    logic        pic_done;
    logic [5:0]  rem;
    logic        more_later;
    logic        load_out;
    logic        run_end;
    logic [12:0] col_after;
    logic [3:0]  plane_p1;
    logic [12:0] row_p1;

    assign pix  = 4'd8 >> geom.depth;
    assign col0 = col_reg << (3'd3 - {1'b0, geom.depth});
    assign diff = geom.width - col0;
    assign lanes = (diff > {9'd0, pix}) ? pix : diff[3:0];
    assign last_line = ({1'b0, plane_reg} + 4'd1 >= geom.planes)
                    && ({1'b0, row_reg} + 13'd1 >= geom.height);
    assign pic_done = last_line && (14'(col_reg) + 14'd1 == 14'(geom.line_bytes));
    assign rem = cnt_reg - 6'd1;
    // Another beat follows in this run if the next byte is still inside the line,
    // or if the column counter wraps back to the start of the line before the run ends.
    assign more_later = (rem != 6'd0)
                     && ((14'(col_reg) + 14'd1 < 14'(geom.line_bytes))
                      || (14'(col_reg) + 14'(rem) >= 14'd8192));

    assign st.start_run   = !finished_reg && (await_reg || ((stream_byte & RUN_MARK) != RUN_MARK));
    assign st.cnt_zero    = (cnt_reg == 6'd0);
    assign st.cnt_last    = (cnt_reg == 6'd1);
    assign st.emit        = !st.cnt_zero && (col_reg < geom.line_bytes);
    assign st.out_blocked = out_valid_reg && !out_ready;

    assign load_out  = cmd.step && st.emit;
    assign run_end   = cmd.step && (st.cnt_zero || st.cnt_last);
    assign col_after = st.cnt_zero ? col_reg : col_reg + 13'd1;
    assign plane_p1  = {1'b0, plane_reg} + 4'd1;
    assign row_p1    = {1'b0, row_reg} + 13'd1;

    always_comb
    begin
        await_next    = await_reg;
        run_len_next  = run_len_reg;
        row_next      = row_reg;
        plane_next    = plane_reg;
        col_next      = col_reg;
        finished_next = finished_reg;
        cnt_next      = cnt_reg;
        value_next    = value_reg;

        if (cmd.accept && !finished_reg)
        begin
            if (await_reg)
            begin
                await_next = 1'b0;
                cnt_next   = run_len_reg;
                value_next = stream_byte;
            end
            else if ((stream_byte & RUN_MARK) == RUN_MARK)
            begin
                await_next   = 1'b1;
                run_len_next = 6'(stream_byte & RUN_MASK);
            end
            else
            begin
                cnt_next   = 6'd1;
                value_next = stream_byte;
            end
        end

        if (cmd.step && !st.cnt_zero)
        begin
            cnt_next = cnt_reg - 6'd1;
            col_next = col_reg + 13'd1;
        end

        if (run_end && (col_after >= geom.line_bytes))
        begin
            col_next = 13'd0;
            if (plane_p1 >= geom.planes)
            begin
                plane_next = 3'd0;
                row_next   = row_p1[11:0];
                if (row_p1 >= geom.height)
                    finished_next = 1'b1;
            end
            else
            begin
                plane_next = plane_p1[2:0];
            end
        end

        if (load_out)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            await_reg     <= 1'b0;
            run_len_reg   <= 6'd0;
            row_reg       <= 12'd0;
            plane_reg     <= 3'd0;
            col_reg       <= 13'd0;
            finished_reg  <= 1'b0;
            cnt_reg       <= 6'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            await_reg     <= await_next;
            run_len_reg   <= run_len_next;
            row_reg       <= row_next;
            plane_reg     <= plane_next;
            col_reg       <= col_next;
            finished_reg  <= finished_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        if (load_out)
        begin
            row_out_reg    <= row_reg;
            plane_out_reg  <= plane_reg;
            col_out_reg    <= col0[11:0];
            lanes_out_reg  <= lanes;
            pixels_out_reg <= unpack_lanes(value_reg, geom.depth, plane_reg, lanes);
            last_out_reg   <= !more_later;
            done_out_reg   <= pic_done;
        end
    end

    assign out_valid    = out_valid_reg;
    assign row_index    = row_out_reg;
    assign plane_index  = plane_out_reg;
    assign first_column = col_out_reg;
    assign lane_count   = lanes_out_reg;
    assign pixel_lanes  = pixels_out_reg;
    assign last_of_run  = last_out_reg;
    assign picture_done = done_out_reg;

    `ASSERT_ALWAYS(a_lanes_range, !out_valid_reg || ((lanes_out_reg != 4'd0) && (lanes_out_reg <= 4'd8)), "bad lane count")
    `ASSERT_NEXT(a_value_taken, cmd.accept && await_reg && !finished_reg, !await_reg, "run value not consumed")
    `ASSERT_ALWAYS(a_done_quiet, !(finished_reg && st.start_run), "run started after picture end")

endmodule

// File: rtl/pcx_rle_plane_unpacker.sv
// Channel  | Handshake             | Payload
// ---------+-----------------------+------------------------------------------------
// input    | in_valid / in_ready   | stream_byte
// output   | out_valid / out_ready | row_index plane_index first_column lane_count
//          |                       | pixel_lanes last_of_run picture_done
// config   | cfg_wr_en             | cfg_index cfg_data
//
// A run-count byte is only accepted. A literal is accepted, then stepped for its beat.
// A run value is accepted, then stepped per byte (once if its count is zero); the step
// sequencer handles one repeated byte per cycle unless stalled, so runs set the rate.
// Accepting the next byte does not wait on the output register; a step that has a beat
// to deliver stalls while that register is full and not taken.
// Reset is asynchronous and active low; there is no clearing pass.
module pcx_rle_plane_unpacker
    import pcxrle_pkg::*;
#(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [1:0]            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [7:0]            stream_byte,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [11:0]           row_index,
    output logic [2:0]            plane_index,
    output logic [11:0]           first_column,
    output logic [3:0]            lane_count,
    output logic [63:0]           pixel_lanes,
    output logic                  last_of_run,
    output logic                  picture_done
);

    geom_t      geom;
    dp_cmd_t    cmd;
    dp_status_t st;

    pcxrle_cfg #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .geom      (geom)
    );

    pcxrle_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .st       (st),
        .cmd      (cmd)
    );

    pcxrle_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .geom         (geom),
        .cmd          (cmd),
        .st           (st),
        .stream_byte  (stream_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .row_index    (row_index),
        .plane_index  (plane_index),
        .first_column (first_column),
        .lane_count   (lane_count),
        .pixel_lanes  (pixel_lanes),
        .last_of_run  (last_of_run),
        .picture_done (picture_done)
    );

endmodule
